>>> rtl/tcfe_pkg.sv
// ----------------------------------------------------------------------------
// tcfe_pkg
// shared opcodes, instruction field layout, and controller/datapath interface
// ----------------------------------------------------------------------------
package tcfe_pkg;

  // item kinds
  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_STEP = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;

  // instruction field masks and positions
  localparam logic [31:0] INS_X_MASK   = 32'h0780_0000;
  localparam logic [31:0] INS_Y_MASK   = 32'h0078_0000;
  localparam logic [31:0] INS_Z_MASK   = 32'h0007_8000;
  localparam logic [31:0] INS_M_MASK   = 32'h007f_ffff;
  localparam logic [31:0] INS_I16_MASK = 32'h0000_FFFF;
  localparam int unsigned INS_OP_LSB   = 27;
  localparam int unsigned INS_X_LSB    = 23;
  localparam int unsigned INS_Y_LSB    = 19;
  localparam int unsigned INS_Z_LSB    = 15;

  // opcodes
  localparam logic [4:0] OP_HALT  = 5'd0;
  localparam logic [4:0] OP_NOP   = 5'd1;
  localparam logic [4:0] OP_NOT   = 5'd2;
  localparam logic [4:0] OP_MOVR  = 5'd3;
  localparam logic [4:0] OP_CMP   = 5'd4;
  localparam logic [4:0] OP_LDBO  = 5'd5;
  localparam logic [4:0] OP_STBO  = 5'd6;
  localparam logic [4:0] OP_ADD   = 5'd7;
  localparam logic [4:0] OP_SUB   = 5'd8;
  localparam logic [4:0] OP_MUL   = 5'd9;
  localparam logic [4:0] OP_DIV   = 5'd10;
  localparam logic [4:0] OP_AND   = 5'd11;
  localparam logic [4:0] OP_OR    = 5'd12;
  localparam logic [4:0] OP_XOR   = 5'd13;
  localparam logic [4:0] OP_LD    = 5'd14;
  localparam logic [4:0] OP_ST    = 5'd15;
  localparam logic [4:0] OP_MOVIL = 5'd16;
  localparam logic [4:0] OP_MOVIH = 5'd17;
  localparam logic [4:0] OP_ADDI  = 5'd18;
  localparam logic [4:0] OP_SUBI  = 5'd19;
  localparam logic [4:0] OP_MULI  = 5'd20;
  localparam logic [4:0] OP_DIVI  = 5'd21;
  localparam logic [4:0] OP_LSH   = 5'd22;
  localparam logic [4:0] OP_RSH   = 5'd23;
  localparam logic [4:0] OP_JE    = 5'd24;
  localparam logic [4:0] OP_JNE   = 5'd25;
  localparam logic [4:0] OP_JL    = 5'd26;
  localparam logic [4:0] OP_JLE   = 5'd27;
  localparam logic [4:0] OP_JG    = 5'd28;
  localparam logic [4:0] OP_JGE   = 5'd29;
  localparam logic [4:0] OP_JMP   = 5'd30;

  // divider operand source
  typedef enum logic [1:0] {
    DIV_SRC_ADDR = 2'd0,
    DIV_SRC_PC   = 2'd1,
    DIV_SRC_DATA = 2'd2,
    DIV_SRC_OPER = 2'd3
  } div_src_e;

  // register file read target
  typedef enum logic [1:0] {
    RF_X = 2'd0,
    RF_Y = 2'd1,
    RF_Z = 2'd2
  } rf_sel_e;

  typedef struct packed {
    logic       capture;
    logic       clr_wr;
    logic       div_start;
    div_src_e   div_src;
    logic       maddr_load;
    logic       mem_rd;
    logic       mem_wr;
    logic [1:0] byte_idx;
    logic       ins_latch;
    logic       rf_rd;
    rf_sel_e    rf_sel;
    logic       finish;
  } tcfe_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       halted;
    logic [4:0] op;
    logic       div_done;
    logic       clr_last;
    logic       out_free;
  } tcfe_stat_t;

endpackage

>>> rtl/tcfe_ram.sv
// ----------------------------------------------------------------------------
// tcfe_ram
// generic simple dual port ram, one write and one registered read
// ----------------------------------------------------------------------------
module tcfe_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/tcfe_div.sv
// ----------------------------------------------------------------------------
// tcfe_div
// 32-bit restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module tcfe_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [31:0] quo_o
);

  logic        busy_q, done_q;
  logic [4:0]  cnt_q;
  logic [31:0] r_q, q_q, d_q;
  logic [32:0] trial;
  logic [32:0] diff;
  logic        ge;

  assign trial = {r_q, q_q[31]};
  assign diff  = trial - {1'b0, d_q};
  assign ge    = trial >= {1'b0, d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      r_q <= '0;
      q_q <= dividend_i;
      d_q <= divisor_i;
    end else if (busy_q) begin
      r_q <= ge ? diff[31:0] : trial[31:0];
      q_q <= {q_q[30:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = q_q;

`ifndef SYNTHESIS
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("divider restarted while busy");
`endif

endmodule

>>> rtl/tcfe_datapath.sv
// ----------------------------------------------------------------------------
// tcfe_datapath
// memories, registers, divider and execute logic driven by controller commands
// ----------------------------------------------------------------------------
module tcfe_datapath #(
  parameter int unsigned MEM_BYTES = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tcfe_pkg::tcfe_cmd_t cmd_i,
  output tcfe_pkg::tcfe_stat_t stat_o,
  input  logic [1:0]         in_kind_i,
  input  logic [39:0]        in_data_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [87:0]        out_data_o
);

  localparam int unsigned AW = $clog2(MEM_BYTES);
  // reciprocal of the memory size, scaled by 2^32
  localparam logic [31:0] AMOD_RECIP = 32'((64'd1 << 32) / 64'(MEM_BYTES));
  localparam logic [31:0] AMOD_BYTES = 32'(MEM_BYTES);

  logic [1:0]  kind_q;
  logic [7:0]  addr_q;
  logic [31:0] data_q;
  logic [7:0]  pc_q, pc_nx;
  logic [2:0]  flags_q, flags_nx;
  logic        halt_q, halt_nx;
  logic [AW-1:0] maddr_q, maddr_nx;
  logic        rd_pend_q;
  logic [31:0] word_q, ins_q;
  logic [31:0] rx_q, ry_q, rz_q;
  logic        rf_pend_q;
  tcfe_pkg::rf_sel_e rf_tgt_q;
  logic [3:0]  rf_ridx_q, rf_raddr;
  logic [15:0] rf_vld_q;
  logic [31:0] rf_rdata, rf_rval;
  logic [7:0]  mem_rdata, mem_wbyte, st_byte;
  logic [31:0] st_src;
  logic        mem_we;
  logic [31:0] div_a, div_b, div_quo;
  logic        div_start, div_done;

  // address reduction pipeline
  logic        am_start;
  logic [3:0]  am_pipe_q;
  logic [31:0] am_src, am_val_q, am_quo_q, am_rem_q, am_back;
  logic [63:0] am_prod;

  logic [4:0]  ins_op;
  logic [3:0]  ins_x, wx, wy, wz;
  logic [31:0] m_w, i16_w, mul_a, mul_b, mul_lo;
  logic        exec, take;
  logic [31:0] res_rd, res_val;
  logic [4:0]  res_op;
  logic        res_wr;
  logic [3:0]  res_idx;

  logic        out_valid_q;
  logic [31:0] o_rd_q, o_val_q;
  logic [7:0]  o_pc_q;
  logic [4:0]  o_op_q;
  logic        o_wr_q, o_halt_q;
  logic [3:0]  o_idx_q;
  logic [2:0]  o_flags_q;

  // instruction fields
  assign ins_op = 5'(ins_q >> tcfe_pkg::INS_OP_LSB);
  assign ins_x  = 4'((ins_q & tcfe_pkg::INS_X_MASK) >> tcfe_pkg::INS_X_LSB);
  assign m_w    = ins_q & tcfe_pkg::INS_M_MASK;
  assign i16_w  = ins_q & tcfe_pkg::INS_I16_MASK;
  // register read indexes come from the freshly fetched word
  assign wx     = 4'((word_q & tcfe_pkg::INS_X_MASK) >> tcfe_pkg::INS_X_LSB);
  assign wy     = 4'((word_q & tcfe_pkg::INS_Y_MASK) >> tcfe_pkg::INS_Y_LSB);
  assign wz     = 4'((word_q & tcfe_pkg::INS_Z_MASK) >> tcfe_pkg::INS_Z_LSB);

  // byte memory
  always_comb begin
    case (cmd_i.byte_idx)
      2'd0:    st_byte = st_src[31:24];
      2'd1:    st_byte = st_src[23:16];
      2'd2:    st_byte = st_src[15:8];
      default: st_byte = st_src[7:0];
    endcase
  end

  assign st_src    = (kind_q == tcfe_pkg::KIND_LOAD) ? data_q : rx_q;
  assign mem_we    = cmd_i.clr_wr | cmd_i.mem_wr;
  assign mem_wbyte = cmd_i.clr_wr ? 8'd0 : st_byte;
  assign maddr_nx  = (maddr_q == AW'(MEM_BYTES - 1)) ? '0 : maddr_q + AW'(1);

  tcfe_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (maddr_q),
    .wdata_i (mem_wbyte),
    .raddr_i (maddr_q),
    .rdata_o (mem_rdata)
  );

  // register file, entries never written read as zero
  always_comb begin
    case (cmd_i.rf_sel)
      tcfe_pkg::RF_X: rf_raddr = wx;
      tcfe_pkg::RF_Y: rf_raddr = wy;
      default:        rf_raddr = wz;
    endcase
  end

  tcfe_ram #(.WIDTH(32), .DEPTH(16)) u_rf (
    .clk_i   (clk_i),
    .we_i    (cmd_i.finish & res_wr),
    .waddr_i (res_idx),
    .wdata_i (res_val),
    .raddr_i (rf_raddr),
    .rdata_o (rf_rdata)
  );

  assign rf_rval = rf_vld_q[rf_ridx_q] ? rf_rdata : '0;

  // address reduction: quotient estimate by reciprocal multiply, remainder,
  // then one correction step; done pulses as the start bit reaches the top of am_pipe_q
  assign am_start  = cmd_i.div_start && (cmd_i.div_src != tcfe_pkg::DIV_SRC_OPER);
  assign div_start = cmd_i.div_start && (cmd_i.div_src == tcfe_pkg::DIV_SRC_OPER);

  always_comb begin
    case (cmd_i.div_src)
      tcfe_pkg::DIV_SRC_ADDR: am_src = {24'd0, addr_q};
      tcfe_pkg::DIV_SRC_PC:   am_src = {24'd0, pc_q};
      default: begin
        am_src = (ins_op == tcfe_pkg::OP_LDBO || ins_op == tcfe_pkg::OP_STBO) ?
                 m_w + ry_q : m_w;
      end
    endcase
  end

  assign am_prod = {32'd0, am_val_q} * {32'd0, AMOD_RECIP};
  assign am_back = am_quo_q * AMOD_BYTES;

  // divider for div and divi
  assign div_a = (ins_op == tcfe_pkg::OP_DIV) ? ry_q : rx_q;
  assign div_b = (ins_op == tcfe_pkg::OP_DIV) ? rz_q : m_w;

  tcfe_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .done_o     (div_done),
    .quo_o      (div_quo)
  );

  // execute
  assign exec   = (kind_q == tcfe_pkg::KIND_STEP) && !halt_q;
  assign mul_a  = (ins_op == tcfe_pkg::OP_MUL) ? ry_q : rx_q;
  assign mul_b  = (ins_op == tcfe_pkg::OP_MUL) ? rz_q : m_w;
  assign mul_lo = mul_a * mul_b;

  always_comb begin
    res_rd   = '0;
    res_op   = '0;
    res_wr   = 1'b0;
    res_idx  = '0;
    res_val  = '0;
    pc_nx    = pc_q;
    flags_nx = flags_q;
    halt_nx  = halt_q;
    take     = 1'b0;
    if (kind_q == tcfe_pkg::KIND_READ) begin
      res_rd = word_q;
    end
    if (exec) begin
      res_op = ins_op;
      pc_nx  = pc_q + 8'd4;
      res_wr = 1'b1;
      case (ins_op)
        tcfe_pkg::OP_HALT: begin
          halt_nx = 1'b1;
          pc_nx   = pc_q;
          res_wr  = 1'b0;
        end
        tcfe_pkg::OP_NOP:   res_wr = 1'b0;
        tcfe_pkg::OP_NOT:   res_val = {31'd0, rx_q == '0};
        tcfe_pkg::OP_MOVR:  res_val = ry_q;
        tcfe_pkg::OP_CMP: begin
          flags_nx = {rx_q > ry_q, rx_q < ry_q, rx_q == ry_q};
          res_wr   = 1'b0;
        end
        tcfe_pkg::OP_LDBO:  res_val = word_q;
        tcfe_pkg::OP_STBO:  res_wr = 1'b0;
        tcfe_pkg::OP_ADD:   res_val = ry_q + rz_q;
        tcfe_pkg::OP_SUB:   res_val = ry_q - rz_q;
        tcfe_pkg::OP_MUL:   res_val = mul_lo;
        tcfe_pkg::OP_DIV:   res_val = div_quo;
        tcfe_pkg::OP_AND:   res_val = ry_q & rz_q;
        tcfe_pkg::OP_OR:    res_val = ry_q | rz_q;
        tcfe_pkg::OP_XOR:   res_val = ry_q ^ rz_q;
        tcfe_pkg::OP_LD:    res_val = word_q;
        tcfe_pkg::OP_ST:    res_wr = 1'b0;
        tcfe_pkg::OP_MOVIL: res_val = i16_w;
        tcfe_pkg::OP_MOVIH: res_val = (rx_q & tcfe_pkg::INS_I16_MASK) | (i16_w << 16);
        tcfe_pkg::OP_ADDI:  res_val = rx_q + m_w;
        tcfe_pkg::OP_SUBI:  res_val = rx_q - m_w;
        tcfe_pkg::OP_MULI:  res_val = mul_lo;
        tcfe_pkg::OP_DIVI:  res_val = div_quo;
        tcfe_pkg::OP_LSH:   res_val = (m_w >= 32'd32) ? '0 : rx_q << m_w[4:0];
        tcfe_pkg::OP_RSH:   res_val = (m_w >= 32'd32) ? '0 : rx_q >> m_w[4:0];
        tcfe_pkg::OP_JE: begin
          take = flags_q[0]; res_wr = 1'b0;
        end
        tcfe_pkg::OP_JNE: begin
          take = !flags_q[0]; res_wr = 1'b0;
        end
        tcfe_pkg::OP_JL: begin
          take = flags_q[1]; res_wr = 1'b0;
        end
        tcfe_pkg::OP_JLE: begin
          take = flags_q[0] | flags_q[1]; res_wr = 1'b0;
        end
        tcfe_pkg::OP_JG: begin
          take = flags_q[2]; res_wr = 1'b0;
        end
        tcfe_pkg::OP_JGE: begin
          take = flags_q[0] | flags_q[2]; res_wr = 1'b0;
        end
        tcfe_pkg::OP_JMP: begin
          take = 1'b1; res_wr = 1'b0;
        end
        default: begin
          pc_nx  = pc_q;
          res_wr = 1'b0;
        end
      endcase
      if (take) begin
        pc_nx = m_w[7:0];
      end
      if (res_wr) begin
        res_idx = ins_x;
      end else begin
        res_val = '0;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= '0;
      flags_q     <= '0;
      halt_q      <= 1'b0;
      maddr_q     <= '0;
      rd_pend_q   <= 1'b0;
      rf_pend_q   <= 1'b0;
      rf_vld_q    <= '0;
      out_valid_q <= 1'b0;
      am_pipe_q   <= '0;
    end else begin
      rd_pend_q <= cmd_i.mem_rd;
      rf_pend_q <= cmd_i.rf_rd;
      am_pipe_q <= {am_pipe_q[2:0], am_start};
      if (cmd_i.maddr_load) begin
        maddr_q <= am_rem_q[AW-1:0];
      end else if (cmd_i.clr_wr || cmd_i.mem_rd || cmd_i.mem_wr) begin
        maddr_q <= maddr_nx;
      end
      if (cmd_i.finish) begin
        pc_q        <= pc_nx;
        flags_q     <= flags_nx;
        halt_q      <= halt_nx;
        out_valid_q <= 1'b1;
        if (res_wr) begin
          rf_vld_q[res_idx] <= 1'b1;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q <= in_kind_i;
      addr_q <= in_data_i[7:0];
      data_q <= in_data_i[39:8];
    end
    if (am_start) begin
      am_val_q <= am_src;
    end
    if (am_pipe_q[0]) begin
      am_quo_q <= am_prod[63:32];
    end
    if (am_pipe_q[1]) begin
      am_rem_q <= am_val_q - am_back;
    end else if (am_pipe_q[2] && (am_rem_q >= AMOD_BYTES)) begin
      am_rem_q <= am_rem_q - AMOD_BYTES;
    end
    if (cmd_i.maddr_load) begin
      word_q <= '0;
    end else if (rd_pend_q) begin
      word_q <= {word_q[23:0], mem_rdata};
    end
    if (cmd_i.ins_latch) begin
      ins_q <= word_q;
    end
    if (cmd_i.rf_rd) begin
      rf_tgt_q  <= cmd_i.rf_sel;
      rf_ridx_q <= rf_raddr;
    end
    if (rf_pend_q) begin
      case (rf_tgt_q)
        tcfe_pkg::RF_X: rx_q <= rf_rval;
        tcfe_pkg::RF_Y: ry_q <= rf_rval;
        default:        rz_q <= rf_rval;
      endcase
    end
    if (cmd_i.finish) begin
      o_rd_q    <= res_rd;
      o_pc_q    <= pc_nx;
      o_op_q    <= res_op;
      o_wr_q    <= res_wr;
      o_idx_q   <= res_idx;
      o_val_q   <= res_val;
      o_flags_q <= flags_nx;
      o_halt_q  <= halt_nx;
    end
  end

  assign stat_o.kind     = kind_q;
  assign stat_o.halted   = halt_q;
  assign stat_o.op       = ins_op;
  assign stat_o.div_done = div_done | am_pipe_q[3];
  assign stat_o.clr_last = (maddr_q == AW'(MEM_BYTES - 1));
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {2'b00, o_halt_q, o_flags_q, o_val_q, o_idx_q, o_wr_q, o_op_q,
                        o_pc_q, o_rd_q};

`ifndef SYNTHESIS
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |=> halt_q) else $error("halted flag cleared");
  a_finish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> (!out_valid_q || out_ready_i)) else $error("result overwritten");
  a_pc_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.finish && kind_q != tcfe_pkg::KIND_STEP) |=> $stable(pc_q))
    else $error("pc moved on a memory item");
  a_amod_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    am_pipe_q[3] |-> (am_rem_q < AMOD_BYTES)) else $error("address not reduced");
`endif

endmodule

>>> rtl/tcfe_ctrl.sv
// ----------------------------------------------------------------------------
// tcfe_ctrl
// sequencer for clearing pass, memory items and instruction steps
// ----------------------------------------------------------------------------
module tcfe_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  tcfe_pkg::tcfe_stat_t stat_i,
  output tcfe_pkg::tcfe_cmd_t  cmd_o
);

  typedef enum logic [11:0] {
    S_CLEAR  = 12'b0000_0000_0001,
    S_IDLE   = 12'b0000_0000_0010,
    S_START  = 12'b0000_0000_0100,
    S_AMOD   = 12'b0000_0000_1000,
    S_FETCH  = 12'b0000_0001_0000,
    S_REGS   = 12'b0000_0010_0000,
    S_DECODE = 12'b0000_0100_0000,
    S_DIV    = 12'b0000_1000_0000,
    S_DMOD   = 12'b0001_0000_0000,
    S_LOAD   = 12'b0010_0000_0000,
    S_STORE  = 12'b0100_0000_0000,
    S_FINISH = 12'b1000_0000_0000
  } state_e;

  state_e     state_q, state_d;
  logic [2:0] cnt_q, cnt_d;
  logic       is_store;

  assign is_store = (stat_i.op == tcfe_pkg::OP_STBO) || (stat_i.op == tcfe_pkg::OP_ST);

  always_comb begin
    cmd_o      = '0;
    state_d    = state_q;
    cnt_d      = cnt_q;
    in_ready_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (stat_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_START;
        end
      end
      S_START: begin
        if (stat_i.kind == tcfe_pkg::KIND_LOAD || stat_i.kind == tcfe_pkg::KIND_READ) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_src   = tcfe_pkg::DIV_SRC_ADDR;
          state_d         = S_AMOD;
        end else if (stat_i.kind == tcfe_pkg::KIND_STEP && !stat_i.halted) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_src   = tcfe_pkg::DIV_SRC_PC;
          state_d         = S_AMOD;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_AMOD: begin
        if (stat_i.div_done) begin
          cmd_o.maddr_load = 1'b1;
          cnt_d            = '0;
          case (stat_i.kind)
            tcfe_pkg::KIND_LOAD: state_d = S_STORE;
            tcfe_pkg::KIND_READ: state_d = S_LOAD;
            default:             state_d = S_FETCH;
          endcase
        end
      end
      S_FETCH: begin
        cmd_o.mem_rd = (cnt_q != 3'd4);
        if (cnt_q == 3'd4) begin
          cnt_d   = '0;
          state_d = S_REGS;
        end else begin
          cnt_d = cnt_q + 3'd1;
        end
      end
      S_REGS: begin
        cmd_o.ins_latch = (cnt_q == 3'd0);
        cmd_o.rf_rd     = (cnt_q != 3'd3);
        case (cnt_q[1:0])
          2'd0:    cmd_o.rf_sel = tcfe_pkg::RF_X;
          2'd1:    cmd_o.rf_sel = tcfe_pkg::RF_Y;
          default: cmd_o.rf_sel = tcfe_pkg::RF_Z;
        endcase
        if (cnt_q == 3'd3) begin
          cnt_d   = '0;
          state_d = S_DECODE;
        end else begin
          cnt_d = cnt_q + 3'd1;
        end
      end
      S_DECODE: begin
        if (stat_i.op == tcfe_pkg::OP_DIV || stat_i.op == tcfe_pkg::OP_DIVI) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_src   = tcfe_pkg::DIV_SRC_OPER;
          state_d         = S_DIV;
        end else if (stat_i.op == tcfe_pkg::OP_LDBO || stat_i.op == tcfe_pkg::OP_LD ||
                     is_store) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_src   = tcfe_pkg::DIV_SRC_DATA;
          state_d         = S_DMOD;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_DIV: begin
        if (stat_i.div_done) begin
          state_d = S_FINISH;
        end
      end
      S_DMOD: begin
        if (stat_i.div_done) begin
          cmd_o.maddr_load = 1'b1;
          cnt_d            = '0;
          state_d          = is_store ? S_STORE : S_LOAD;
        end
      end
      S_LOAD: begin
        cmd_o.mem_rd = (cnt_q != 3'd4);
        if (cnt_q == 3'd4) begin
          cnt_d   = '0;
          state_d = S_FINISH;
        end else begin
          cnt_d = cnt_q + 3'd1;
        end
      end
      S_STORE: begin
        cmd_o.mem_wr   = 1'b1;
        cmd_o.byte_idx = cnt_q[1:0];
        if (cnt_q == 3'd3) begin
          cnt_d   = '0;
          state_d = S_FINISH;
        end else begin
          cnt_d = cnt_q + 3'd1;
        end
      end
      S_FINISH: begin
        if (stat_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

>>> rtl/tiny_cpu_fetch_execute.sv
// ----------------------------------------------------------------------------
// tiny_cpu_fetch_execute
// multicycle 32-bit processor core driven one item at a time over streams
// ----------------------------------------------------------------------------
// Each input beat is a load word, a step (fetch, decode and execute one
// instruction) or a read word; each produces exactly one result beat. After
// reset the byte memory is swept to zero, one byte per cycle, and no input
// beat is taken until the sweep ends. Items are worked one at a time. Every
// byte address is reduced modulo MEM_BYTES (reciprocal multiply, remainder,
// one correction). A load word goes through the reduction and four byte
// writes, a read word through the reduction and four byte reads. A step goes
// through the reduction, four byte fetches from the byte memory, three
// register file reads and decode, then a second reduction and four byte
// reads for a data load or four byte writes for a data store, or a
// bit-serial divide for div and divi. A halted step or an unused kind goes
// straight to the finish. The next beat is taken only from the idle state
// that follows the finish. A finished result sits in the output register, so
// the next beat is taken while it waits; that item then stalls before
// finishing until the result register frees up.
module tiny_cpu_fetch_execute #(
  parameter int unsigned MEM_BYTES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // address [7:0], data [39:8]
  input  logic [39:0] s_axis_tdata,
  // kind [1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // read_data [31:0], pc_after [39:32], opcode [44:40], reg_written [45],
  // reg_index [49:46], reg_value [81:50], flag_equal [82], flag_less [83],
  // flag_greater [84], halted [85], zero fill [87:86]
  output logic [87:0] m_axis_tdata
);

  tcfe_pkg::tcfe_cmd_t  cmd;
  tcfe_pkg::tcfe_stat_t stat;

  // state machine: sequences memory sweeps, fetches and executes
  tcfe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // datapath: memories, register file, divider, alu and result register
  tcfe_datapath #(.MEM_BYTES(MEM_BYTES)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_kind_i   (s_axis_tuser),
    .in_data_i   (s_axis_tdata),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata)
  );

endmodule

>>> tb/tb_tiny_cpu_fetch_execute_checker.sv
// ----------------------------------------------------------------------------
// tb_tiny_cpu_fetch_execute_checker
// watches both streams, keeps a shadow copy of the processor state, predicts
// the result beat of every accepted item and compares it field by field
// ----------------------------------------------------------------------------
module tb_tiny_cpu_fetch_execute_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [87:0] m_axis_tdata,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [1:0]  fill;
    logic        halted;
    logic        flag_greater;
    logic        flag_less;
    logic        flag_equal;
    logic [31:0] reg_value;
    logic [3:0]  reg_index;
    logic        reg_written;
    logic [4:0]  opcode;
    logic [7:0]  pc_after;
    logic [31:0] read_data;
  } cpu_result_t;

  logic [7:0]  shadow_mem [256];
  logic [31:0] shadow_regs [16];
  logic [7:0]  shadow_pc;
  logic        flag_e, flag_l, flag_g, shadow_halted;
  cpu_result_t expected_results [$];

  assign pending_o = expected_results.size();

  function automatic logic [31:0] mem_word(logic [7:0] addr);
    return {shadow_mem[addr], shadow_mem[8'(addr + 1)], shadow_mem[8'(addr + 2)],
            shadow_mem[8'(addr + 3)]};
  endfunction

  task automatic mem_store(logic [7:0] addr, logic [31:0] w);
    shadow_mem[addr]         = w[31:24];
    shadow_mem[8'(addr + 1)] = w[23:16];
    shadow_mem[8'(addr + 2)] = w[15:8];
    shadow_mem[8'(addr + 3)] = w[7:0];
  endtask

  function automatic logic [31:0] udiv(logic [31:0] n, logic [31:0] d);
    return (d == 0) ? 32'hFFFF_FFFF : n / d;
  endfunction

  // advance the shadow state by one item and build its result beat
  task automatic execute_item(logic [1:0] kind, logic [7:0] addr, logic [31:0] data,
                              output cpu_result_t res);
    logic [31:0] ins, rx, ry, rz, m, i16, wval;
    logic [3:0]  xi;
    logic [4:0]  op;
    logic [7:0]  next_pc;
    logic        wrote, take;
    res = '0;
    if (kind == tcfe_pkg::KIND_LOAD) begin
      mem_store(addr, data);
    end else if (kind == tcfe_pkg::KIND_READ) begin
      res.read_data = mem_word(addr);
    end else if (kind == tcfe_pkg::KIND_STEP && !shadow_halted) begin
      ins     = mem_word(shadow_pc);
      op      = ins[31:27];
      xi      = ins[26:23];
      rx      = shadow_regs[xi];
      ry      = shadow_regs[ins[22:19]];
      rz      = shadow_regs[ins[18:15]];
      m       = ins & tcfe_pkg::INS_M_MASK;
      i16     = ins & tcfe_pkg::INS_I16_MASK;
      next_pc = 8'(shadow_pc + 4);
      wrote   = 1'b1;
      take    = 1'b0;
      wval    = '0;
      case (op)
        tcfe_pkg::OP_HALT: begin
          shadow_halted = 1'b1; next_pc = shadow_pc; wrote = 1'b0;
        end
        tcfe_pkg::OP_NOP:   wrote = 1'b0;
        tcfe_pkg::OP_NOT:   wval = (rx == 0) ? 32'd1 : 32'd0;
        tcfe_pkg::OP_MOVR:  wval = ry;
        tcfe_pkg::OP_CMP: begin
          flag_e = (rx == ry); flag_l = (rx < ry); flag_g = (rx > ry); wrote = 1'b0;
        end
        tcfe_pkg::OP_LDBO:  wval = mem_word(8'(m + ry));
        tcfe_pkg::OP_STBO: begin mem_store(8'(m + ry), rx); wrote = 1'b0; end
        tcfe_pkg::OP_ADD:   wval = ry + rz;
        tcfe_pkg::OP_SUB:   wval = ry - rz;
        tcfe_pkg::OP_MUL:   wval = ry * rz;
        tcfe_pkg::OP_DIV:   wval = udiv(ry, rz);
        tcfe_pkg::OP_AND:   wval = ry & rz;
        tcfe_pkg::OP_OR:    wval = ry | rz;
        tcfe_pkg::OP_XOR:   wval = ry ^ rz;
        tcfe_pkg::OP_LD:    wval = mem_word(m[7:0]);
        tcfe_pkg::OP_ST: begin mem_store(m[7:0], rx); wrote = 1'b0; end
        tcfe_pkg::OP_MOVIL: wval = i16;
        tcfe_pkg::OP_MOVIH: wval = (rx & tcfe_pkg::INS_I16_MASK) | (i16 << 16);
        tcfe_pkg::OP_ADDI:  wval = rx + m;
        tcfe_pkg::OP_SUBI:  wval = rx - m;
        tcfe_pkg::OP_MULI:  wval = rx * m;
        tcfe_pkg::OP_DIVI:  wval = udiv(rx, m);
        tcfe_pkg::OP_LSH:   wval = (m >= 32) ? 32'd0 : rx << m;
        tcfe_pkg::OP_RSH:   wval = (m >= 32) ? 32'd0 : rx >> m;
        tcfe_pkg::OP_JE:  begin take = flag_e;           wrote = 1'b0; end
        tcfe_pkg::OP_JNE: begin take = !flag_e;          wrote = 1'b0; end
        tcfe_pkg::OP_JL:  begin take = flag_l;           wrote = 1'b0; end
        tcfe_pkg::OP_JLE: begin take = flag_e || flag_l; wrote = 1'b0; end
        tcfe_pkg::OP_JG:  begin take = flag_g;           wrote = 1'b0; end
        tcfe_pkg::OP_JGE: begin take = flag_e || flag_g; wrote = 1'b0; end
        tcfe_pkg::OP_JMP: begin take = 1'b1;             wrote = 1'b0; end
        default: begin next_pc = shadow_pc; wrote = 1'b0; end
      endcase
      if (take) next_pc = m[7:0];
      if (wrote) begin
        shadow_regs[xi] = wval;
        res.reg_index   = xi;
        res.reg_value   = wval;
      end
      res.reg_written = wrote;
      res.opcode      = op;
      shadow_pc       = next_pc;
    end
    res.pc_after     = shadow_pc;
    res.flag_equal   = flag_e;
    res.flag_less    = flag_l;
    res.flag_greater = flag_g;
    res.halted       = shadow_halted;
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    cpu_result_t exp_r, act_r, new_r;
    if (!rst_ni) begin
      foreach (shadow_mem[i]) shadow_mem[i] = '0;
      foreach (shadow_regs[i]) shadow_regs[i] = '0;
      shadow_pc     = '0;
      flag_e        = 1'b0;
      flag_l        = 1'b0;
      flag_g        = 1'b0;
      shadow_halted = 1'b0;
      fail_count_o  = 0;
      expected_results.delete();
    end else begin
      // retire first: a result never belongs to the item taken on the same edge
      if (m_axis_tvalid && m_axis_tready) begin
        act_r = m_axis_tdata;
        if (expected_results.size() == 0) begin
          $error("result beat with no item outstanding: 0x%0h", m_axis_tdata);
          fail_count_o++;
        end else begin
          exp_r = expected_results.pop_front();
          check_field("read_data", exp_r.read_data, act_r.read_data);
          check_field("pc_after", 32'(exp_r.pc_after), 32'(act_r.pc_after));
          check_field("opcode", 32'(exp_r.opcode), 32'(act_r.opcode));
          check_field("reg_written", 32'(exp_r.reg_written), 32'(act_r.reg_written));
          check_field("reg_index", 32'(exp_r.reg_index), 32'(act_r.reg_index));
          check_field("reg_value", exp_r.reg_value, act_r.reg_value);
          check_field("flag_equal", 32'(exp_r.flag_equal), 32'(act_r.flag_equal));
          check_field("flag_less", 32'(exp_r.flag_less), 32'(act_r.flag_less));
          check_field("flag_greater", 32'(exp_r.flag_greater),
                      32'(act_r.flag_greater));
          check_field("halted", 32'(exp_r.halted), 32'(act_r.halted));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        execute_item(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[39:8], new_r);
        expected_results.push_back(new_r);
      end
    end
  end

  final begin
    if (expected_results.size() != 0) $error("%0d results never arrived",
                                             expected_results.size());
  end

endmodule

>>> tb/tb_tiny_cpu_fetch_execute.sv
// ----------------------------------------------------------------------------
// tb_tiny_cpu_fetch_execute
// stimulus and verdict for the processor core: a directed program exercising
// wrap, divide by zero, large shifts and the dead opcode, a randomized code
// image with random steps, loads and reads, and a final halt phase
// ----------------------------------------------------------------------------
module tb_tiny_cpu_fetch_execute;

  // kind code with no defined action
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic [4:0] OP_DEAD     = 5'd31;
  // code lives in the low half, data in the high half
  localparam logic [7:0] LOOP_ADDR   = 8'd124;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // address [7:0], data [39:8]
  logic [39:0] s_axis_tdata;
  // kind [1:0]
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // read_data [31:0], pc_after [39:32], opcode [44:40], reg_written [45],
  // reg_index [49:46], reg_value [81:50], flag_equal [82], flag_less [83],
  // flag_greater [84], halted [85], zero fill [87:86]
  logic [87:0] m_axis_tdata;

  int fail_count;
  int pending;
  int burst_left;
  int out_beats;

  tiny_cpu_fetch_execute dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  tb_tiny_cpu_fetch_execute_checker checker_i (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // hard stop far beyond the slowest legal run
  initial begin
    #6000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic [31:0] encode(logic [4:0] op, logic [3:0] x, logic [22:0] m);
    return {op, x, m};
  endfunction

  // random instruction for the code area; never a halt
  function automatic logic [31:0] random_instr();
    logic [4:0]  op;
    logic [22:0] m;
    op = 5'($urandom_range(1, 30));
    if ($urandom_range(0, 299) == 0) op = OP_DEAD;
    m = 23'($urandom);
    case (op)
      // jump targets stay word aligned inside the code area
      tcfe_pkg::OP_JE, tcfe_pkg::OP_JNE, tcfe_pkg::OP_JL, tcfe_pkg::OP_JLE,
      tcfe_pkg::OP_JG, tcfe_pkg::OP_JGE, tcfe_pkg::OP_JMP:
        m[7:0] = 8'($urandom_range(0, 31) * 4);
      // absolute accesses go to the data area
      tcfe_pkg::OP_LD, tcfe_pkg::OP_ST: m[7:0] = 8'($urandom_range(128, 252));
      tcfe_pkg::OP_LSH, tcfe_pkg::OP_RSH:
        if ($urandom_range(0, 3) != 0) m = 23'($urandom_range(0, 40));
      tcfe_pkg::OP_DIVI: if ($urandom_range(0, 3) == 0) m = '0;
      tcfe_pkg::OP_DIV, tcfe_pkg::OP_MULI:
        if ($urandom_range(0, 1) == 0) m = 23'($urandom_range(0, 15));
      default: ;
    endcase
    return encode(op, 4'($urandom), m);
  endfunction

  // offer one beat in bursts; returns on the edge that accepted it
  task automatic send_beat(logic [1:0] kind, logic [7:0] addr, logic [31:0] data);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {data, addr};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    burst_left--;
  endtask

  // receiver: changing ready patterns plus one long hold-off
  initial begin
    int mode;
    int hold;
    bit held;
    m_axis_tready = 1'b0;
    out_beats = 0;
    held = 1'b0;
    mode = 0;
    hold = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) out_beats++;
      if (!held && out_beats >= 300) begin
        // stall long enough for the core to back up onto its input
        held = 1'b1;
        hold = 600;
      end
      if (hold > 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else begin
        if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 3);
        case (mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= ($urandom_range(0, 3) != 0);
          2: m_axis_tready <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready <= ($urandom_range(0, 9) < 1) ? 1'b0 : 1'b1;
        endcase
      end
    end
  end

  initial begin
    int n;
    int pick;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = tcfe_pkg::KIND_LOAD;
    burst_left    = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: all-ones build, divide by zero, shift by 32, dead opcode
    send_beat(tcfe_pkg::KIND_LOAD, 8'd0,  encode(tcfe_pkg::OP_MOVIL, 4'd1, 23'h00FFFF));
    send_beat(tcfe_pkg::KIND_LOAD, 8'd4,  encode(tcfe_pkg::OP_MOVIH, 4'd1, 23'h00FFFF));
    send_beat(tcfe_pkg::KIND_LOAD, 8'd8,  encode(tcfe_pkg::OP_DIVI,  4'd1, 23'd0));
    send_beat(tcfe_pkg::KIND_LOAD, 8'd12, encode(tcfe_pkg::OP_LSH,   4'd1, 23'd32));
    send_beat(tcfe_pkg::KIND_LOAD, 8'd16, encode(OP_DEAD,            4'd0, 23'd0));
    send_beat(tcfe_pkg::KIND_LOAD, 8'd20, encode(tcfe_pkg::OP_JMP,   4'd0, 23'h7FFF00));
    repeat (6) send_beat(tcfe_pkg::KIND_STEP, 8'd0, 32'd0);
    // replace the dead opcode with a compare, then run through the jump
    send_beat(tcfe_pkg::KIND_LOAD, 8'd16, encode(tcfe_pkg::OP_CMP, 4'd1, 23'h7FFFFF));
    send_beat(tcfe_pkg::KIND_STEP, 8'd0, 32'd0);
    send_beat(tcfe_pkg::KIND_STEP, 8'd0, 32'd0);
    // word access wrapping past the top of memory
    send_beat(tcfe_pkg::KIND_READ, 8'd254, 32'hFFFF_FFFF);
    send_beat(tcfe_pkg::KIND_LOAD, 8'd254, 32'hFFFF_FFFF);
    send_beat(tcfe_pkg::KIND_READ, 8'd254, 32'd0);
    send_beat(tcfe_pkg::KIND_READ, 8'd0, 32'd0);
    send_beat(KIND_UNUSED, 8'd255, 32'hFFFF_FFFF);

    // fill the code area, closing it with a jump back to zero
    for (int a = 0; a < LOOP_ADDR; a += 4) begin
      send_beat(tcfe_pkg::KIND_LOAD, 8'(a), random_instr());
    end
    send_beat(tcfe_pkg::KIND_LOAD, LOOP_ADDR, encode(tcfe_pkg::OP_JMP, 4'd0, 23'd0));

    // random traffic, mostly steps through the live program
    n = 0;
    while (n < 1800) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        send_beat(tcfe_pkg::KIND_STEP, 8'($urandom), $urandom);
      end else if (pick < 80) begin
        send_beat(tcfe_pkg::KIND_LOAD, 8'($urandom_range(0, 30) * 4), random_instr());
      end else if (pick < 88) begin
        send_beat(tcfe_pkg::KIND_LOAD, 8'($urandom), $urandom);
      end else if (pick < 96) begin
        send_beat(tcfe_pkg::KIND_READ, 8'($urandom), $urandom);
      end else begin
        send_beat(KIND_UNUSED, 8'($urandom), $urandom);
      end
      n++;
    end

    // halt phase: zero every word so the next fetch halts, then poke around
    for (int a = 0; a < 256; a += 4) send_beat(tcfe_pkg::KIND_LOAD, 8'(a), 32'd0);
    repeat (3) send_beat(tcfe_pkg::KIND_STEP, 8'd0, 32'd0);
    send_beat(tcfe_pkg::KIND_LOAD, 8'd40, 32'hA5A5_5A5A);
    send_beat(tcfe_pkg::KIND_READ, 8'd40, 32'd0);
    send_beat(tcfe_pkg::KIND_STEP, 8'd0, 32'd0);
    s_axis_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/tcfe_pkg.sv
rtl/tcfe_ram.sv
rtl/tcfe_div.sv
rtl/tcfe_datapath.sv
rtl/tcfe_ctrl.sv
rtl/tiny_cpu_fetch_execute.sv
tb/tb_tiny_cpu_fetch_execute_checker.sv
tb/tb_tiny_cpu_fetch_execute.sv
